// ===== design/doubly_linked_list_table_core_macros.svh =====
// Assertion macros for the doubly linked list table core.
// Included by every RTL file that carries concurrent assertions.
// Defining SYNTH turns each macro into an empty body.
`ifndef DOUBLY_LINKED_LIST_TABLE_CORE_MACROS_SVH
`define DOUBLY_LINKED_LIST_TABLE_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication: when ante holds, cons must hold at that edge.
`define DLLT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dllt assertion failed");
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define DLLT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dllt assertion failed");
`else
`define DLLT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define DLLT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/dllt_pkg.sv =====
// Shared types, constants and helpers for the doubly linked list table core.
// No dependencies; used by the interfaces, the node memory, the sequencer and the top level.
package dllt_pkg;

  localparam int ID_W          = 10;
  localparam int DATA_W        = 32;
  localparam int ST_W          = 2;
  localparam int MAX_NODES_DEF = 1023;

  // Link write queue: one command needs at most four link writes
  localparam int Q_DEPTH   = 4;
  localparam int Q_IDX_W   = $clog2(Q_DEPTH);
  localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_BADKEY = 2'd2;

  typedef enum logic [2:0] {
    K_PUSH_HEAD  = 3'd0,
    K_PUSH_TAIL  = 3'd1,
    K_INS_AFTER  = 3'd2,
    K_INS_BEFORE = 3'd3,
    K_DELETE     = 3'd4,
    K_MOVE_HEAD  = 3'd5,
    K_MOVE_TAIL  = 3'd6,
    K_READ       = 3'd7
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic [ID_W-1:0]           key;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]           status;
    logic [ID_W-1:0]           new_id;
    logic [ID_W-1:0]           head_id;
    logic [ID_W-1:0]           tail_id;
    logic signed [DATA_W-1:0]  node_value;
    logic [ID_W-1:0]           node_next;
    logic [ID_W-1:0]           node_prev;
  } res_t;

  // Masked write into the link memory: either field or both
  typedef struct packed {
    logic            en_prev;
    logic            en_next;
    logic [ID_W-1:0] addr;
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] next;
  } lnk_wr_t;

  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   addr;
    logic              live;
    logic [DATA_W-1:0] data;
  } dat_wr_t;

  // Registered read of one node: both memories at the same address
  typedef struct packed {
    logic              live;
    logic [DATA_W-1:0] data;
    logic [ID_W-1:0]   prev;
    logic [ID_W-1:0]   next;
  } node_rd_t;

  function automatic lnk_wr_t mk_op(input logic [ID_W-1:0] addr, input logic en_p,
                                    input logic en_n, input logic [ID_W-1:0] p,
                                    input logic [ID_W-1:0] n);
    lnk_wr_t op;
    op.en_prev = en_p;
    op.en_next = en_n;
    op.addr    = addr;
    op.prev    = p;
    op.next    = n;
    return op;
  endfunction

endpackage

// ===== design/dllt_cmd_if.sv =====
// Command channel: valid/ready handshake carrying kind, key and value.
// Depends on dllt_pkg for field widths.
interface dllt_cmd_if;
  import dllt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [2:0]               kind;
  logic [ID_W-1:0]          key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

// ===== design/dllt_rsp_if.sv =====
// Result channel: valid/ready handshake carrying status, ids and node fields.
// Depends on dllt_pkg for field widths.
interface dllt_rsp_if;
  import dllt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic [ID_W-1:0]          new_id;
  logic [ID_W-1:0]          head_id;
  logic [ID_W-1:0]          tail_id;
  logic signed [DATA_W-1:0] node_value;
  logic [ID_W-1:0]          node_next;
  logic [ID_W-1:0]          node_prev;

  modport source (output valid, status, new_id, head_id, tail_id, node_value,
                  node_next, node_prev, input ready);
  modport sink   (input valid, status, new_id, head_id, tail_id, node_value,
                  node_next, node_prev, output ready);
endinterface

// ===== design/doubly_linked_list_table_core.sv =====
// Doubly linked list table core.
//
// Commands arrive on cmd (kind, key, value) and each produces exactly one
// transaction on rsp (status, new_id, head_id, tail_id and the node fields of a
// read). Both channels move a transaction on a clock edge with valid and ready high.
// Nodes live in a link memory and a data memory (registered read);
// node numbers come from a bump allocator and are never reused.
//
// With rsp.ready high, the result is valid and cmd.ready is back once the sequencer
// has passed evaluation, n link-memory writes and its finish state; no command is
// taken before then. n (0 to 4) counts the writes through the single link write port:
// an insert into an empty list takes 1, a push or an insert at an end 2, an insert in
// the middle 3, a delete up to 2, a move up to 4, a read or a rejected command none.
//
// Reset (rst, synchronous) empties the list and clears the allocator; the
// memories need no clearing since unwritten entries are never read.
// A result waits in the output register while rsp.ready is low; the next
// command is still taken and computed, and its result holds in the sequencer
// (with cmd.ready low) until the output register frees up.
`include "doubly_linked_list_table_core_macros.svh"
module doubly_linked_list_table_core #(
  parameter int MAX_NODES = dllt_pkg::MAX_NODES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  dllt_cmd_if.sink       cmd,
  dllt_rsp_if.source     rsp
);
  import dllt_pkg::*;

  logic     accept;
  logic     seq_idle;
  logic     res_load;
  logic     res_free;
  logic     rsp_valid;
  cmd_t     cmd_in;
  res_t     seq_res;
  res_t     rsp_q;
  node_rd_t rd;
  lnk_wr_t  lnk_wr;
  dat_wr_t  dat_wr;

  // take a command only when the sequencer has finished the previous one
  assign cmd.ready = seq_idle;
  assign accept    = cmd.valid && cmd.ready;
  assign cmd_in    = '{kind: kind_t'(cmd.kind), key: cmd.key, value: cmd.value};

  // output slot frees when empty or when the current transaction drains now
  assign res_free = !rsp_valid || rsp.ready;

  // node read is launched at the accepting edge, data is back for evaluation
  dllt_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (cmd.key),
    .rd      (rd),
    .lnk_wr  (lnk_wr),
    .dat_wr  (dat_wr)
  );

  dllt_seq #(
    .MAX_NODES (MAX_NODES)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .cmd_in   (cmd_in),
    .rd       (rd),
    .res_free (res_free),
    .idle     (seq_idle),
    .res_load (res_load),
    .res      (seq_res),
    .lnk_wr   (lnk_wr),
    .dat_wr   (dat_wr)
  );

  // output register: hold until taken, reload on the same edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      rsp_q <= seq_res;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.status     = rsp_q.status;
  assign rsp.new_id     = rsp_q.new_id;
  assign rsp.head_id    = rsp_q.head_id;
  assign rsp.tail_id    = rsp_q.tail_id;
  assign rsp.node_value = rsp_q.node_value;
  assign rsp.node_next  = rsp_q.node_next;
  assign rsp.node_prev  = rsp_q.node_prev;

  `DLLT_ASSERT_NEXT(a_busy_after_accept, clk, rst, accept, !cmd.ready)
  `DLLT_ASSERT_IMPL(a_no_overwrite, clk, rst, res_load, !rsp_valid || rsp.ready)
  `DLLT_ASSERT_NEXT(a_valid_from_load, clk, rst, !rsp_valid && !res_load, !rsp_valid)

endmodule

// ===== design/dllt_mem.sv =====
// Node storage: link memory (prev/next, per-field write) and data memory (live flag, value).
// One read port with registered data, one write port per memory. Depends on dllt_pkg.
module dllt_mem #(
  parameter int MAX_NODES = dllt_pkg::MAX_NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [dllt_pkg::ID_W-1:0]   rd_addr,
  output dllt_pkg::node_rd_t          rd,
  input  dllt_pkg::lnk_wr_t           lnk_wr,
  input  dllt_pkg::dat_wr_t           dat_wr
);
  import dllt_pkg::*;

  localparam int DEPTH = MAX_NODES + 1;
  localparam int AW    = $clog2(DEPTH);

  typedef struct packed {
    logic [ID_W-1:0] prev;
    logic [ID_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic              live;
    logic [DATA_W-1:0] data;
  } dent_t;

  link_t link_mem [DEPTH];
  dent_t data_mem [DEPTH];

  logic [AW-1:0] rd_a;
  logic [AW-1:0] lw_a;
  logic [AW-1:0] dw_a;
  link_t         link_q;
  dent_t         dent_q;

  assign rd_a = AW'(rd_addr);
  assign lw_a = AW'(lnk_wr.addr);
  assign dw_a = AW'(dat_wr.addr);

  always_ff @(posedge clk) begin
    if (lnk_wr.en_prev) begin
      link_mem[lw_a].prev <= lnk_wr.prev;
    end
    if (lnk_wr.en_next) begin
      link_mem[lw_a].next <= lnk_wr.next;
    end
    if (rd_en) begin
      link_q <= link_mem[rd_a];
    end
  end

  always_ff @(posedge clk) begin
    if (dat_wr.en) begin
      data_mem[dw_a] <= '{live: dat_wr.live, data: dat_wr.data};
    end
    if (rd_en) begin
      dent_q <= data_mem[rd_a];
    end
  end

  assign rd = '{live: dent_q.live, data: dent_q.data, prev: link_q.prev, next: link_q.next};

endmodule

// ===== design/dllt_seq.sv =====
// Command sequencer: evaluates one command from the node read, keeps head/tail/allocator,
// then drains a short queue of link writes. Depends on dllt_pkg and the assertion macros.
`include "doubly_linked_list_table_core_macros.svh"
module dllt_seq #(
  parameter int MAX_NODES = dllt_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dllt_pkg::cmd_t     cmd_in,
  input  dllt_pkg::node_rd_t rd,
  input  logic               res_free,
  output logic               idle,
  output logic               res_load,
  output dllt_pkg::res_t     res,
  output dllt_pkg::lnk_wr_t  lnk_wr,
  output dllt_pkg::dat_wr_t  dat_wr
);
  import dllt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_WR   = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state, state_next;
  cmd_t                 cmd_q;
  logic [ID_W-1:0]      head, tail, last_alloc;
  lnk_wr_t              q [Q_DEPTH];
  logic [Q_CNT_W-1:0]   q_cnt;

  // evaluation results
  lnk_wr_t              ops [Q_DEPTH];
  logic [Q_CNT_W-1:0]   n_ops;
  logic [ID_W-1:0]      e_head, e_tail, e_la, e_new;
  logic [ST_W-1:0]      e_status;
  logic [DATA_W-1:0]    e_nv;
  logic [ID_W-1:0]      e_nn, e_np;
  dat_wr_t              e_dat;

  logic [ID_W-1:0]      k, a, b, id, h1, t1;
  logic                 key_ok, full, is_alloc;

  assign k        = cmd_q.key;
  assign a        = rd.prev;
  assign b        = rd.next;
  assign id       = last_alloc + ID_W'(1);
  assign key_ok   = (k != '0) && (k <= last_alloc) && rd.live;
  assign full     = (32'(last_alloc) >= 32'(MAX_NODES));
  assign is_alloc = (cmd_q.kind == K_PUSH_HEAD) || (cmd_q.kind == K_PUSH_TAIL) ||
                    (cmd_q.kind == K_INS_AFTER) || (cmd_q.kind == K_INS_BEFORE);
  // list ends once the keyed node is cut out
  assign h1       = (a == '0) ? b : head;
  assign t1       = (b == '0) ? a : tail;

  always_comb begin
    e_status = ST_OK;
    e_new    = '0;
    e_nv     = '0;
    e_nn     = '0;
    e_np     = '0;
    e_head   = head;
    e_tail   = tail;
    e_la     = last_alloc;
    e_dat    = '0;
    n_ops    = '0;
    for (int i = 0; i < Q_DEPTH; i++) begin
      ops[i] = '0;
    end

    if (is_alloc) begin
      if (full) begin
        e_status = ST_FULL;
      end else if ((cmd_q.kind == K_INS_AFTER || cmd_q.kind == K_INS_BEFORE) &&
                   head != '0 && !key_ok) begin
        e_status = ST_BADKEY;
      end else begin
        e_la  = id;
        e_new = id;
        e_dat = '{en: 1'b1, addr: id, live: 1'b1, data: cmd_q.value};
        if (head == '0) begin
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(id, 1'b1, 1'b1, '0, '0);
          n_ops  = n_ops + Q_CNT_W'(1);
          e_head = id;
          e_tail = id;
        end else if (cmd_q.kind == K_PUSH_HEAD ||
                     (cmd_q.kind == K_INS_BEFORE && k == head)) begin
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(id, 1'b1, 1'b1, '0, head);
          n_ops  = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(head, 1'b1, 1'b0, id, '0);
          n_ops  = n_ops + Q_CNT_W'(1);
          e_head = id;
        end else if (cmd_q.kind == K_PUSH_TAIL ||
                     (cmd_q.kind == K_INS_AFTER && k == tail)) begin
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(tail, 1'b0, 1'b1, '0, id);
          n_ops  = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(id, 1'b1, 1'b1, tail, '0);
          n_ops  = n_ops + Q_CNT_W'(1);
          e_tail = id;
        end else if (cmd_q.kind == K_INS_AFTER) begin
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(k, 1'b0, 1'b1, '0, id);
          n_ops = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(id, 1'b1, 1'b1, k, b);
          n_ops = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(b, 1'b1, 1'b0, id, '0);
          n_ops = n_ops + Q_CNT_W'(1);
        end else begin
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(a, 1'b0, 1'b1, '0, id);
          n_ops = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(id, 1'b1, 1'b1, a, k);
          n_ops = n_ops + Q_CNT_W'(1);
          ops[n_ops[Q_IDX_W-1:0]] = mk_op(k, 1'b1, 1'b0, id, '0);
          n_ops = n_ops + Q_CNT_W'(1);
        end
      end
    end else if (!key_ok) begin
      e_status = ST_BADKEY;
    end else begin
      case (cmd_q.kind) inside
        K_DELETE, K_MOVE_HEAD, K_MOVE_TAIL: begin
          // unlink, skipped for a move that leaves the node where it is
          if (cmd_q.kind == K_DELETE || (cmd_q.kind == K_MOVE_HEAD && k != head) ||
              (cmd_q.kind == K_MOVE_TAIL && k != tail)) begin
            if (a != '0) begin
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(a, 1'b0, 1'b1, '0, b);
              n_ops = n_ops + Q_CNT_W'(1);
            end
            if (b != '0) begin
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(b, 1'b1, 1'b0, a, '0);
              n_ops = n_ops + Q_CNT_W'(1);
            end
            e_head = h1;
            e_tail = t1;
            if (cmd_q.kind == K_DELETE) begin
              e_dat = '{en: 1'b1, addr: k, live: 1'b0, data: rd.data};
            end else if ((cmd_q.kind == K_MOVE_HEAD && h1 == '0) ||
                         (cmd_q.kind == K_MOVE_TAIL && t1 == '0)) begin
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(k, 1'b1, 1'b1, '0, '0);
              n_ops  = n_ops + Q_CNT_W'(1);
              e_head = k;
              e_tail = k;
            end else if (cmd_q.kind == K_MOVE_HEAD) begin
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(k, 1'b1, 1'b1, '0, h1);
              n_ops  = n_ops + Q_CNT_W'(1);
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(h1, 1'b1, 1'b0, k, '0);
              n_ops  = n_ops + Q_CNT_W'(1);
              e_head = k;
            end else begin
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(t1, 1'b0, 1'b1, '0, k);
              n_ops  = n_ops + Q_CNT_W'(1);
              ops[n_ops[Q_IDX_W-1:0]] = mk_op(k, 1'b1, 1'b1, t1, '0);
              n_ops  = n_ops + Q_CNT_W'(1);
              e_tail = k;
            end
          end
        end
        K_READ: begin
          e_nv = rd.data;
          e_nn = b;
          e_np = a;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_EVAL;
      S_EVAL: state_next = (n_ops != '0) ? S_WR : S_FIN;
      S_WR:   if (q_cnt == Q_CNT_W'(1)) state_next = S_FIN;
      S_FIN:  if (res_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      last_alloc <= '0;
      q_cnt      <= '0;
    end else begin
      state <= state_next;
      if (state == S_EVAL) begin
        head       <= e_head;
        tail       <= e_tail;
        last_alloc <= e_la;
        q_cnt      <= n_ops;
      end else if (state == S_WR) begin
        q_cnt <= q_cnt - Q_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cmd_q <= cmd_in;
    end
    if (state == S_EVAL) begin
      q   <= ops;
      res <= '{status: e_status, new_id: e_new, head_id: e_head, tail_id: e_tail,
               node_value: e_nv, node_next: e_nn, node_prev: e_np};
    end else if (state == S_WR) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q[i] <= q[i + 1];
      end
      q[Q_DEPTH-1] <= '0;
    end
  end

  always_comb begin
    lnk_wr         = q[0];
    lnk_wr.en_prev = q[0].en_prev && (state == S_WR);
    lnk_wr.en_next = q[0].en_next && (state == S_WR);
    dat_wr         = e_dat;
    dat_wr.en      = e_dat.en && (state == S_EVAL);
  end

  assign idle     = (state == S_IDLE);
  assign res_load = (state == S_FIN) && res_free;

  `DLLT_ASSERT_IMPL(a_wr_has_ops, clk, rst, state == S_WR, q_cnt != '0)
  `DLLT_ASSERT_IMPL(a_ends_agree, clk, rst, 1'b1, (head == '0) == (tail == '0))
  `DLLT_ASSERT_IMPL(a_head_allocated, clk, rst, 1'b1, head <= last_alloc && tail <= last_alloc)
  `DLLT_ASSERT_NEXT(a_alloc_monotonic, clk, rst, 1'b1, last_alloc >= $past(last_alloc))

endmodule
